// ===== hw/rtl/factorial_binomial_unit_defines.svh =====
// ----------------------------------------------------------------------------
// factorial_binomial_unit_defines
// assertion macros shared by the factorial and binomial unit
// ----------------------------------------------------------------------------
`ifndef FACTORIAL_BINOMIAL_UNIT_DEFINES_SVH
`define FACTORIAL_BINOMIAL_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FBU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FBU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fbu_pkg.sv =====
// ----------------------------------------------------------------------------
// fbu_pkg
// types and constants of the factorial and binomial unit
// ----------------------------------------------------------------------------
`default_nettype none

package fbu_pkg;

    localparam int FIELD_W = 64;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;

    typedef logic [OP_W-1:0] opcode_t;
    typedef logic [ST_W-1:0] status_t;

    localparam opcode_t OP_FALL   = 3'd0;
    localparam opcode_t OP_RISE   = 3'd1;
    localparam opcode_t OP_FACT   = 3'd2;
    localparam opcode_t OP_MULTI  = 3'd3;
    localparam opcode_t OP_DOUBLE = 3'd4;
    localparam opcode_t OP_BINOM  = 3'd5;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_INVALID = 2'd1;
    localparam status_t ST_RANGE   = 2'd2;

    typedef struct packed {
        opcode_t              opcode;
        logic [FIELD_W-1:0]   n_value;
        logic [FIELD_W-1:0]   k_value;
    } req_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   result_value;
        status_t              status;
    } rsp_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep_a;
        logic prep_b;
        logic mul_start;
        logic mul_commit;
        logic div_start;
        logic div_commit;
        logic out_load;
    } fbu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic early_done;
        logic loop_done;
        logic need_div;
        logic mul_done;
        logic mul_ovf;
        logic div_done;
    } fbu_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/factorial_binomial_unit.sv =====
// ----------------------------------------------------------------------------
// factorial_binomial_unit
// falling, rising and partial factorial, multifactorial, double factorial and
// binomial coefficient with overflow-checked multiplies
// ----------------------------------------------------------------------------
// One transaction is worked on at a time; the result register lets the next
// request in while a finished result still waits. A request's run time grows
// with the number of multiply steps actually done (at most about 65, since an
// overflow ends the loop), plus a division for every binomial step from the
// second on. The multiply step is set by the shared 32x32 multiplier, which
// builds each product from four partial products; the binomial division is a
// one-bit-per-cycle restoring divider. Early cases (zero operands, bad ranges)
// finish straight after setup.
`default_nettype none

module factorial_binomial_unit
    import fbu_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req_data,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp_data
);

    fbu_cmd_t  cmd;
    fbu_stat_t st;

    fbu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .st        (st),
        .cmd       (cmd)
    );

    fbu_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .st       (st),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/fbu_mul.sv =====
// ----------------------------------------------------------------------------
// fbu_mul
// overflow-checked multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fbu_mul
    import fbu_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] a,
    input  wire logic [VALUE_WIDTH-1:0] b,
    output logic                        done,
    output logic                        ovf,
    output logic [VALUE_WIDTH-1:0]      prod_lo
);

    localparam int VW = VALUE_WIDTH;
    localparam int MW = 64;
    localparam int HW = MW / 2;
    localparam logic [2:0] PH_LAST = 3'd4;

    logic [MW-1:0]   a_reg;
    logic [MW-1:0]   b_reg;
    logic [2*MW-1:0] prod_reg;
    logic [2*MW-1:0] prod_next;
    logic [MW-1:0]   pp_reg;
    logic [MW-1:0]   pp_next;
    logic [1:0]      pp_sh_reg;
    logic            pp_vld_reg;
    logic [2:0]      ph_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [HW-1:0]   a_half;
    logic [HW-1:0]   b_half;
    logic [2*MW-1:0] pp_shifted;

    assign a_half     = ph_reg[1] ? a_reg[MW-1:HW] : a_reg[HW-1:0];
    assign b_half     = ph_reg[0] ? b_reg[MW-1:HW] : b_reg[HW-1:0];
    assign pp_next    = MW'(a_half) * MW'(b_half);
    assign pp_shifted = (2*MW)'(pp_reg) << {pp_sh_reg, 5'b0};
    assign prod_next  = prod_reg + pp_shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ph_reg     <= '0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (ph_reg == PH_LAST);
            if (start)
            begin
                busy_reg   <= 1'b1;
                ph_reg     <= '0;
                pp_vld_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (ph_reg == PH_LAST)
                begin
                    busy_reg   <= 1'b0;
                    pp_vld_reg <= 1'b0;
                end
                else
                begin
                    ph_reg     <= ph_reg + 3'd1;
                    pp_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= MW'(a);
            b_reg    <= MW'(b);
            prod_reg <= '0;
        end
        else
        begin
            if (busy_reg && (ph_reg != PH_LAST))
            begin
                pp_reg    <= pp_next;
                pp_sh_reg <= {1'b0, ph_reg[1]} + {1'b0, ph_reg[0]};
            end
            if (pp_vld_reg)
            begin
                prod_reg <= prod_next;
            end
        end
    end

    assign done    = done_reg;
    assign ovf     = (prod_reg >> VW) != '0;
    assign prod_lo = prod_reg[VW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/fbu_div.sv =====
// ----------------------------------------------------------------------------
// fbu_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fbu_div
    import fbu_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      quotient
);

    localparam int VW    = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VW + 1);

    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    quo_reg;
    logic [VW-1:0]    d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VW:0]      rem_shift;
    logic [VW:0]      diff;
    logic             ge;

    assign rem_shift = {rem_reg, quo_reg[VW-1]};
    assign diff      = rem_shift - {1'b0, d_reg};
    assign ge        = rem_shift >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : rem_shift[VW-1:0];
            quo_reg <= {quo_reg[VW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fbu_dp.sv =====
// ----------------------------------------------------------------------------
// fbu_dp
// datapath: operand setup, running product, loop registers, result register
// ----------------------------------------------------------------------------
`default_nettype none

module fbu_dp
    import fbu_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_item_t req_data,
    input  wire fbu_cmd_t  cmd,
    output fbu_stat_t      st,
    output rsp_item_t      rsp_data
);

    localparam int VW     = VALUE_WIDTH;
    localparam int STEP_W = (VW < 32) ? VW : 32;

    opcode_t       op_reg;
    logic [VW-1:0] n_reg;
    logic [VW-1:0] k_reg;
    logic [VW:0]   sum_reg;
    logic          half_le_reg;
    logic [VW-1:0] acc_reg;
    logic [VW-1:0] fac_reg;
    logic [VW-1:0] step_reg;
    logic [VW-1:0] cnt_reg;
    logic [VW-1:0] idx_reg;
    logic          count_mode_reg;
    logic          binom_reg;
    status_t       ovf_code_reg;
    status_t       stat_reg;
    rsp_item_t     out_reg;

    // setup decode
    logic          early_done;
    logic [VW-1:0] early_val;
    status_t       early_st;
    logic [VW-1:0] fac0;
    logic [VW-1:0] step0;
    logic [VW-1:0] cnt0;
    logic          count_mode0;
    logic          binom0;
    status_t       ovf_code0;
    logic [VW-1:0] mstep;
    logic [VW:0]   rise_dec;
    logic [VW-1:0] fact_cnt;
    logic [VW-1:0] bin_m;
    logic [VW-1:0] bin_fac;

    logic          mul_done;
    logic          mul_ovf;
    logic [VW-1:0] mul_prod;
    logic          div_done;
    logic [VW-1:0] div_quo;

    assign mstep    = VW'(k_reg[STEP_W-1:0]);
    assign rise_dec = sum_reg - (VW+1)'(1);
    assign fact_cnt = sum_reg[VW-1:0] + VW'(1);
    assign bin_m    = half_le_reg ? k_reg : sum_reg[VW-1:0];
    assign bin_fac  = n_reg - bin_m + VW'(1);

    always_comb
    begin
        early_done  = 1'b0;
        early_val   = '0;
        early_st    = ST_OK;
        fac0        = n_reg;
        step0       = VW'(1);
        cnt0        = k_reg;
        count_mode0 = 1'b1;
        binom0      = 1'b0;
        ovf_code0   = ST_INVALID;
        unique case (op_reg)
            OP_FALL:
            begin
                // borrow of n - k means k above n
                if (sum_reg[VW])
                begin
                    early_done = 1'b1;
                    early_st   = ST_INVALID;
                end
            end
            OP_RISE:
            begin
                fac0 = rise_dec[VW-1:0];
                if (n_reg == '0)
                begin
                    early_done = 1'b1;
                    early_st   = ST_INVALID;
                end
                else if (k_reg == '0)
                begin
                    early_done = 1'b1;
                    early_val  = VW'(1);
                end
                else if (rise_dec[VW])
                begin
                    early_done = 1'b1;
                    early_st   = ST_INVALID;
                end
            end
            OP_FACT:
            begin
                cnt0 = fact_cnt;
                if (n_reg == '0)
                begin
                    early_done = 1'b1;
                    early_val  = VW'(1);
                end
                else if ((k_reg == '0) || sum_reg[VW])
                begin
                    early_done = 1'b1;
                    early_st   = ST_INVALID;
                end
            end
            OP_MULTI:
            begin
                count_mode0 = 1'b0;
                ovf_code0   = ST_RANGE;
                step0       = mstep;
                if (mstep == '0)
                begin
                    early_done = 1'b1;
                    early_st   = ST_INVALID;
                end
                else if (n_reg < mstep)
                begin
                    early_done = 1'b1;
                    early_val  = VW'(1);
                end
            end
            OP_DOUBLE:
            begin
                count_mode0 = 1'b0;
                ovf_code0   = ST_RANGE;
                step0       = VW'(2);
                if (n_reg < VW'(2))
                begin
                    early_done = 1'b1;
                    early_val  = VW'(1);
                end
            end
            OP_BINOM:
            begin
                binom0    = 1'b1;
                ovf_code0 = ST_RANGE;
                fac0      = bin_fac;
                cnt0      = bin_m;
                if (sum_reg[VW])
                begin
                    early_done = 1'b1;
                end
                else if ((k_reg == '0) || (k_reg == n_reg))
                begin
                    early_done = 1'b1;
                    early_val  = VW'(1);
                end
            end
            default:
            begin
                early_done = 1'b1;
                early_st   = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req_data.opcode;
            n_reg  <= req_data.n_value[VW-1:0];
            k_reg  <= req_data.k_value[VW-1:0];
        end
        if (cmd.prep_a)
        begin
            sum_reg     <= (op_reg == OP_RISE) ? ({1'b0, n_reg} + {1'b0, k_reg})
                                               : ({1'b0, n_reg} - {1'b0, k_reg});
            half_le_reg <= k_reg <= (n_reg >> 1);
        end
        if (cmd.prep_b)
        begin
            acc_reg        <= early_done ? early_val : VW'(1);
            stat_reg       <= early_st;
            fac_reg        <= fac0;
            step_reg       <= step0;
            cnt_reg        <= cnt0;
            idx_reg        <= VW'(1);
            count_mode_reg <= count_mode0;
            binom_reg      <= binom0;
            ovf_code_reg   <= ovf_code0;
        end
        if (cmd.mul_commit)
        begin
            if (mul_ovf)
            begin
                stat_reg <= ovf_code_reg;
            end
            else
            begin
                acc_reg <= mul_prod;
                fac_reg <= binom_reg ? (fac_reg + VW'(1)) : (fac_reg - step_reg);
                cnt_reg <= cnt_reg - VW'(1);
                idx_reg <= idx_reg + VW'(1);
            end
        end
        if (cmd.div_commit)
        begin
            acc_reg <= div_quo;
        end
        if (cmd.out_load)
        begin
            out_reg.result_value <= (stat_reg == ST_OK) ? FIELD_W'(acc_reg) : '0;
            out_reg.status       <= stat_reg;
        end
    end

    fbu_mul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (acc_reg),
        .b       (fac_reg),
        .done    (mul_done),
        .ovf     (mul_ovf),
        .prod_lo (mul_prod)
    );

    // the divisor is the step index before the commit bumps it
    fbu_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mul_prod),
        .divisor  (idx_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign st.early_done = early_done;
    assign st.loop_done  = count_mode_reg ? (cnt_reg == '0) : (fac_reg < step_reg);
    assign st.need_div   = binom_reg && (idx_reg != VW'(1));
    assign st.mul_done   = mul_done;
    assign st.mul_ovf    = mul_ovf;
    assign st.div_done   = div_done;

    assign rsp_data = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fbu_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbu_ctrl
// controller: sequences setup, multiply and divide steps, owns both handshakes
// ----------------------------------------------------------------------------
`default_nettype none
`include "factorial_binomial_unit_defines.svh"

module fbu_ctrl
    import fbu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    input  wire fbu_stat_t st,
    output fbu_cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP_A = 7'b0000010,
        S_PREP_B = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP_A;
                end
            end
            S_PREP_A:
            begin
                cmd.prep_a = 1'b1;
                state_next = S_PREP_B;
            end
            S_PREP_B:
            begin
                cmd.prep_b = 1'b1;
                state_next = st.early_done ? S_DONE : S_CHECK;
            end
            S_CHECK:
            begin
                if (st.loop_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                if (st.mul_done)
                begin
                    cmd.mul_commit = 1'b1;
                    if (st.mul_ovf)
                    begin
                        state_next = S_DONE;
                    end
                    else if (st.need_div)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.div_commit = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_DONE:
            begin
                // result register free, or its transaction completes now
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    `FBU_ASSERT_NXT(a_accept_starts_setup, req_valid && !req_stall, state_reg == S_PREP_A, "accepted transaction did not start setup")
    `FBU_ASSERT_IMP(a_mul_done_in_mul, st.mul_done, state_reg == S_MUL, "multiplier finished outside multiply state")
    `FBU_ASSERT_IMP(a_div_done_in_div, st.div_done, state_reg == S_DIV, "divider finished outside divide state")
    `FBU_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !out_valid_reg || !rsp_stall, "result register overwritten while stalled")

endmodule

`default_nettype wire

// ===== bench/fbu_checker.sv =====
// ----------------------------------------------------------------------------
// fbu_checker
// predicts each result of the factorial and binomial unit and checks it
// ----------------------------------------------------------------------------
// Watches both channels. Every request transaction is turned into its
// expected value and status by an independent model of the arithmetic. The
// prediction is queued in order, and each response transaction is compared
// field by field with the oldest queued prediction.
module fbu_checker
    import fbu_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire logic      req_stall,
    input  wire req_item_t req_data,
    input  wire logic      rsp_valid,
    input  wire logic      rsp_stall,
    input  wire rsp_item_t rsp_data,
    output int             mismatches,
    output int             outstanding
);

    typedef logic [FIELD_W-1:0] word_t;

    localparam word_t VALUE_MAX   = {FIELD_W{1'b1}} >> (FIELD_W - VALUE_WIDTH);
    localparam word_t STEP_MASK   = 64'h0000_0000_FFFF_FFFF;
    localparam int    PRINT_LIMIT = 40;

    typedef struct {
        req_item_t req;
        rsp_item_t rsp;
    } prediction_t;

    prediction_t expected_results[$];
    int          fail_count = 0;
    int          pending    = 0;

    assign mismatches  = fail_count;
    assign outstanding = pending;

    function automatic rsp_item_t outcome(word_t value, status_t status);
        rsp_item_t r;
        r.result_value = (status == ST_OK) ? value : '0;
        r.status       = status;
        return r;
    endfunction

    // product of a and f, flagged when it does not fit in VALUE_WIDTH bits
    function automatic bit mul_fits(word_t a, word_t f, output word_t p);
        logic [2*FIELD_W-1:0] wide;
        wide = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, f};
        p    = wide[FIELD_W-1:0];
        return wide <= {{FIELD_W{1'b0}}, VALUE_MAX};
    endfunction

    function automatic rsp_item_t falling_product(word_t n, word_t k);
        word_t acc;
        word_t j;
        word_t p;
        acc = 1;
        if (k > n)
            return outcome(0, ST_INVALID);
        for (j = 0; j < k; j++)
        begin
            if (!mul_fits(acc, n - j, p))
                return outcome(0, ST_INVALID);
            acc = p;
        end
        return outcome(acc, ST_OK);
    endfunction

    function automatic rsp_item_t rising_product(word_t n, word_t k);
        if (n == 0)
            return outcome(0, ST_INVALID);
        if (k == 0)
            return outcome(1, ST_OK);
        if (k > VALUE_MAX - n + 1)
            return outcome(0, ST_INVALID);
        return falling_product(n - 1 + k, k);
    endfunction

    function automatic rsp_item_t span_product(word_t n, word_t start);
        if (n == 0)
            return outcome(1, ST_OK);
        if (start == 0 || start > n)
            return outcome(0, ST_INVALID);
        return falling_product(n, n - start + 1);
    endfunction

    function automatic rsp_item_t stepped_product(word_t n, word_t step);
        word_t acc;
        word_t i;
        word_t p;
        acc = 1;
        if (step == 0)
            return outcome(0, ST_INVALID);
        if (n < step)
            return outcome(1, ST_OK);
        for (i = n; i >= step; i -= step)
        begin
            if (!mul_fits(acc, i, p))
                return outcome(0, ST_RANGE);
            acc = p;
        end
        return outcome(acc, ST_OK);
    endfunction

    // multiply first, overflow checked before the exact division
    function automatic rsp_item_t choose(word_t n, word_t k);
        word_t acc;
        word_t m;
        word_t i;
        word_t p;
        acc = 1;
        if (k > n)
            return outcome(0, ST_OK);
        if (k == 0 || k == n)
            return outcome(1, ST_OK);
        m = (k <= n / 2) ? k : n - k;
        for (i = 1; i <= m; i++)
        begin
            if (!mul_fits(acc, n - m + i, p))
                return outcome(0, ST_RANGE);
            acc = p / i;
        end
        return outcome(acc, ST_OK);
    endfunction

    function automatic rsp_item_t compute_result(req_item_t req);
        word_t n;
        word_t k;
        n = req.n_value & VALUE_MAX;
        k = req.k_value & VALUE_MAX;
        case (req.opcode)
            OP_FALL:   return falling_product(n, k);
            OP_RISE:   return rising_product(n, k);
            OP_FACT:   return span_product(n, k);
            OP_MULTI:  return stepped_product(n, k & STEP_MASK);
            OP_DOUBLE: return stepped_product(n, 2);
            OP_BINOM:  return choose(n, k);
            default:   return outcome(0, ST_INVALID);
        endcase
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want, req_item_t req);
        if (fail_count < PRINT_LIMIT)
            $display("%0t: %s mismatch, got %h expected %h (op %0d n %h k %h)",
                     $time, what, got, want, req.opcode, req.n_value, req.k_value);
        fail_count++;
    endtask

    // check the response before queuing the request of the same edge
    always @(posedge clk)
    begin : monitor
        prediction_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transaction", rsp_data.result_value, '0,
                                    '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_data.result_value !== want.rsp.result_value)
                        report_mismatch("value", rsp_data.result_value,
                                        want.rsp.result_value, want.req);
                    if (rsp_data.status !== want.rsp.status)
                        report_mismatch("status", word_t'(rsp_data.status),
                                        word_t'(want.rsp.status), want.req);
                end
            end
            if (req_valid && !req_stall)
            begin
                want.req = req_data;
                want.rsp = compute_result(req_data);
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the factorial and binomial unit
// ----------------------------------------------------------------------------
// Sends a directed set of edge cases for every operation, then random
// requests weighted toward operands that give real results, in bursts with
// random gaps. The response side stalls in changing patterns and twice holds
// off long enough to back the unit up. Checking is done by fbu_checker.
module tb_top;
    import fbu_pkg::*;

    typedef logic [FIELD_W-1:0] word_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_e;

    localparam opcode_t OP_SPARE_LO  = 3'd6;
    localparam opcode_t OP_SPARE_HI  = 3'd7;
    localparam word_t   ALL_ONES     = '1;
    localparam int      RANDOM_ITEMS = 1625;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      HOLD_ITEMS   = 16;
    localparam int      IDLE_LIMIT   = 40000;
    localparam int      DRAIN_CYCLES = 300;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_data;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp_data;
    int        mismatches;
    int        outstanding;
    int        hold_requests = 0;

    always #2 clk = ~clk;

    factorial_binomial_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    fbu_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic word_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_item_t request(opcode_t op, word_t n, word_t k);
        req_item_t r;
        r.opcode  = op;
        r.n_value = n;
        r.k_value = k;
        return r;
    endfunction

    function automatic word_t pick_k(word_t n);
        case ($urandom_range(0, 9))
            0:       return rand64();
            1:       return n - word_t'($urandom_range(0, 3));
            2, 3:    return word_t'($urandom_range(0, 4));
            default: return (n <= 70) ? word_t'($urandom_range(0, 32'(n) + 2))
                                      : word_t'($urandom_range(0, 70));
        endcase
    endfunction

    // mostly small operands, so that results are real and loops run long
    function automatic req_item_t random_request();
        opcode_t ops[6];
        word_t   n;
        word_t   k;
        opcode_t op;
        ops = '{OP_FALL, OP_RISE, OP_FACT, OP_MULTI, OP_DOUBLE, OP_BINOM};
        if ($urandom_range(0, 99) < 4)
            return request($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, rand64(), rand64());
        op = ops[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
            0:       n = rand64();
            1:       n = rand64() >> $urandom_range(0, 63);
            2:       n = {32'd0, $urandom};
            default: n = word_t'($urandom_range(0, 70));
        endcase
        k = pick_k(n);
        if (op == OP_MULTI && $urandom_range(0, 1) == 1)
            k[63:32] = $urandom;
        return request(op, n, k);
    endfunction

    task automatic send_request(req_item_t item);
        @(negedge clk);
        req_valid = 1'b1;
        req_data  = item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        req_valid = 1'b0;
        req_data  = request(opcode_t'($urandom), rand64(), rand64());
        repeat (cycles - 1) @(negedge clk);
    endtask

    initial
    begin : rsp_stall_gen
        int          served;
        int          span;
        int          tick;
        stall_mode_e mode;
        served    = 0;
        span      = 0;
        tick      = 0;
        mode      = STALL_NONE;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != served)
            begin
                served    = hold_requests;
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            if (span == 0)
            begin
                mode = stall_mode_e'($urandom_range(0, 3));
                span = $urandom_range(20, 200);
            end
            span--;
            tick++;
            case (mode)
                STALL_NONE:     rsp_stall = 1'b0;
                STALL_RANDOM:   rsp_stall = ($urandom_range(0, 9) < 3);
                STALL_PERIODIC: rsp_stall = ((tick % 5) < 3);
                default:        rsp_stall = ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[factorial_binomial_unit] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int burst;
        int sent;
        int next_hold;
        int next_drain;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_request(request(OP_FALL, 10, 3));
        send_request(request(OP_FALL, 5, 6));
        send_request(request(OP_FALL, 7, 0));
        send_request(request(OP_FALL, ALL_ONES, 2));
        send_request(request(OP_FALL, 20, 20));
        send_request(request(OP_RISE, 0, 5));
        send_request(request(OP_RISE, 9, 0));
        send_request(request(OP_RISE, ALL_ONES, 2));
        send_request(request(OP_RISE, 3, 4));
        send_request(request(OP_RISE, 21, 21));
        send_request(request(OP_FACT, 0, ALL_ONES));
        send_request(request(OP_FACT, 10, 0));
        send_request(request(OP_FACT, 10, 11));
        send_request(request(OP_FACT, 20, 1));
        send_request(request(OP_FACT, 21, 1));
        // step zero once the upper half is dropped
        send_request(request(OP_MULTI, 10, 64'h0000_0001_0000_0000));
        send_request(request(OP_MULTI, 3, 5));
        send_request(request(OP_MULTI, 30, 64'hFFFF_FFFF_0000_0003));
        send_request(request(OP_MULTI, ALL_ONES, 1));
        send_request(request(OP_DOUBLE, 33, ALL_ONES));
        send_request(request(OP_DOUBLE, ALL_ONES, 0));
        send_request(request(OP_BINOM, 5, 7));
        send_request(request(OP_BINOM, 0, 0));
        send_request(request(OP_BINOM, 9, 9));
        send_request(request(OP_BINOM, 66, 33));
        send_request(request(OP_BINOM, ALL_ONES, 1));
        send_request(request(OP_SPARE_LO, 4, 2));
        send_request(request(OP_SPARE_HI, ALL_ONES, ALL_ONES));

        sent       = 0;
        next_hold  = 500;
        next_drain = 300;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst) send_request(random_request());
            sent += burst;
            if (sent >= next_hold)
            begin
                // receiver holds off while short requests keep coming
                hold_requests++;
                repeat (HOLD_ITEMS)
                    send_request(request(OP_FALL, rand64() >> $urandom_range(0, 63),
                                         word_t'($urandom_range(0, 3))));
                sent      += HOLD_ITEMS;
                next_hold += 700;
            end
            else if (sent >= next_drain)
            begin
                pause_sender(1);
                wait (outstanding == 0);
                next_drain += 600;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 10));
            end
        end

        @(negedge clk);
        req_valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[factorial_binomial_unit] OK");
        else
            $display("[factorial_binomial_unit] ERROR");
        $finish;
    end

endmodule
